[design/bpa_pkg.sv]
// Shared codes and fixed widths for the block pool allocator.
package bpa_pkg;

  localparam int unsigned BLK_BYTES_W  = 24;
  localparam int unsigned POOL_BYTES_W = 34;
  localparam int unsigned CFG_DATA_W   = 34;
  localparam int unsigned CFG_INDEX_W  = 1;
  localparam int unsigned STATUS_W     = 3;

  typedef logic [STATUS_W-1:0]    status_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam status_t ST_APPENDED = 3'd0;
  localparam status_t ST_REUSED   = 3'd1;
  localparam status_t ST_NOMEM    = 3'd2;
  localparam status_t ST_FREED    = 3'd3;
  localparam status_t ST_BADID    = 3'd4;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam cfg_index_t CFG_BLK_BYTES  = 1'b0;
  localparam cfg_index_t CFG_POOL_BYTES = 1'b1;

  localparam logic [BLK_BYTES_W-1:0]  BLK_BYTES_RST  = 24'd64;
  localparam logic [POOL_BYTES_W-1:0] POOL_BYTES_RST = 34'd65536;

endpackage

[design/bpa_cap_check.sv]
// Capacity check: may one more block be appended within the pool size.
module bpa_cap_check #(
  parameter int unsigned PW = 11
) (
  input  logic [PW-1:0]                         appended,
  input  logic [bpa_pkg::BLK_BYTES_W-1:0]       blk_bytes,
  input  logic [bpa_pkg::POOL_BYTES_W-1:0]      pool_bytes,
  output logic                                  cap_ok
);

  localparam int unsigned PRODW = PW + bpa_pkg::BLK_BYTES_W;
  localparam int unsigned CMPW  = (PRODW > bpa_pkg::POOL_BYTES_W) ? PRODW
                                                                 : bpa_pkg::POOL_BYTES_W;

  logic [PW-1:0]    count_inc;
  logic [PRODW-1:0] bytes_needed;

  // count_inc may wrap when appended is already at the bound; the core gates that case
  assign count_inc    = appended + PW'(1);
  assign bytes_needed = PRODW'(count_inc) * PRODW'(blk_bytes);
  assign cap_ok       = CMPW'(bytes_needed) <= CMPW'(pool_bytes);

endmodule

[design/bpa_link_mem.sv]
// Link word memory: one write port, one registered read port with write forwarding.
module bpa_link_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 11
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // a write to the address being fetched wins
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/bpa_core.sv]
// Allocator state, request decision and result register.
module bpa_core #(
  parameter int unsigned MAX_BLOCKS = 1024,
  parameter int unsigned IDW        = 10,
  parameter int unsigned PW         = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_valid,
  input  logic                         item_kind,
  input  logic [IDW-1:0]               item_id,
  input  logic                         cap_ok,
  input  logic [PW-1:0]                link_rd,
  output logic [PW-1:0]                appended,
  output logic                         link_we,
  output logic [IDW-1:0]               link_wa,
  output logic [PW-1:0]                link_wd,
  output logic [IDW-1:0]               link_ra,
  output logic                         out_valid,
  output bpa_pkg::status_t             out_status,
  output logic [IDW-1:0]               out_granted_id,
  output logic [PW-1:0]                out_used_count,
  output logic [PW-1:0]                out_appended_count
);

  localparam logic [PW-1:0] NULL_PTR = PW'(MAX_BLOCKS);

  // head_next_r caches the link word of the head so a pop needs no read latency;
  // the memory fetches the link of head_next_nxt in the same cycle
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] head_next_r, head_next_nxt;
  logic [PW-1:0] appended_r, appended_nxt;
  logic [PW-1:0] used_r, used_nxt;

  logic                out_valid_r;
  bpa_pkg::status_t    status_r, status_nxt;
  logic [IDW-1:0]      granted_r, granted_nxt;
  logic [PW-1:0]       used_out_r;
  logic [PW-1:0]       app_out_r;

  logic list_nonempty;
  logic do_pop, do_append, do_free, is_alloc;

  assign list_nonempty = head_r < NULL_PTR;
  assign is_alloc      = item_valid && (item_kind == bpa_pkg::KIND_ALLOC);
  assign do_pop        = is_alloc && list_nonempty;
  assign do_append     = is_alloc && !list_nonempty && (appended_r < NULL_PTR) && cap_ok;
  assign do_free       = item_valid && (item_kind == bpa_pkg::KIND_FREE)
                         && (PW'(item_id) < appended_r);

  always_comb begin
    head_nxt      = head_r;
    head_next_nxt = head_next_r;
    appended_nxt  = appended_r;
    used_nxt      = used_r;
    granted_nxt   = '0;
    status_nxt    = bpa_pkg::ST_NOMEM;
    if (do_pop) begin
      head_nxt      = head_next_r;
      // head linked to itself: this pop clears that very link
      head_next_nxt = (head_next_r == head_r) ? NULL_PTR : link_rd;
      granted_nxt   = head_r[IDW-1:0];
      status_nxt    = bpa_pkg::ST_REUSED;
    end else if (do_append) begin
      appended_nxt  = appended_r + PW'(1);
      granted_nxt   = appended_r[IDW-1:0];
      status_nxt    = bpa_pkg::ST_APPENDED;
    end else if (do_free) begin
      head_nxt      = PW'(item_id);
      head_next_nxt = head_r;
      status_nxt    = bpa_pkg::ST_FREED;
    end else if (item_kind == bpa_pkg::KIND_FREE) begin
      status_nxt    = bpa_pkg::ST_BADID;
    end
    if ((do_pop || do_append) && (used_r < NULL_PTR)) begin
      used_nxt = used_r + PW'(1);
    end else if (do_free && (used_r != '0)) begin
      used_nxt = used_r - PW'(1);
    end
  end

  // a pop clears the taken block's link, a free links the block to the old head
  assign link_we = do_pop || do_free;
  assign link_wa = do_pop ? head_r[IDW-1:0] : item_id;
  assign link_wd = do_pop ? NULL_PTR : head_r;
  assign link_ra = head_next_nxt[IDW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= NULL_PTR;
      head_next_r <= NULL_PTR;
      appended_r  <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      head_next_r <= head_next_nxt;
      appended_r  <= appended_nxt;
      used_r      <= used_nxt;
      out_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      status_r   <= status_nxt;
      granted_r  <= granted_nxt;
      used_out_r <= used_nxt;
      app_out_r  <= appended_nxt;
    end
  end

  assign appended           = appended_r;
  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_granted_id     = granted_r;
  assign out_used_count     = used_out_r;
  assign out_appended_count = app_out_r;

endmodule

[design/block_pool_allocator_unit.sv]
// Top level of the fixed-size block pool allocator.
//
//  channel  ports                                       handshake
//  -------  ------------------------------------------  -----------------------------
//  request  in_kind, in_block_id                        taken when start && !busy
//  result   out_status, out_granted_id,                 out_valid strobe, one cycle
//           out_used_count, out_appended_count
//  config   cfg_we, cfg_index, cfg_wdata                written when cfg_we high
//
//  One item per cycle; each result appears after its item passes the input register,
//  then decision logic into the result register.
//  The decision path is bounded by the capacity multiply and the link memory fetch.
//  busy is never raised: nothing inside can hold requests off.
//  Synchronous reset empties the free list, clears both counts and restores config.
//  The link memory needs no clearing pass; an entry's value is used only after being written.
module block_pool_allocator_unit #(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_kind,
  input  logic [$clog2(MAX_BLOCKS)-1:0]          in_block_id,
  output logic                                   out_valid,
  output bpa_pkg::status_t                       out_status,
  output logic [$clog2(MAX_BLOCKS)-1:0]          out_granted_id,
  output logic [$clog2(MAX_BLOCKS+1)-1:0]        out_used_count,
  output logic [$clog2(MAX_BLOCKS+1)-1:0]        out_appended_count,
  input  logic                                   cfg_we,
  input  bpa_pkg::cfg_index_t                    cfg_index,
  input  logic [bpa_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int unsigned IDW = $clog2(MAX_BLOCKS);
  localparam int unsigned PW  = $clog2(MAX_BLOCKS + 1);

  logic [bpa_pkg::BLK_BYTES_W-1:0]  blk_bytes_r;
  logic [bpa_pkg::POOL_BYTES_W-1:0] pool_bytes_r;

  logic           item_valid_r;
  logic           item_kind_r;
  logic [IDW-1:0] item_id_r;

  logic           cap_ok;
  logic [PW-1:0]  appended;
  logic           link_we;
  logic [IDW-1:0] link_wa;
  logic [PW-1:0]  link_wd;
  logic [IDW-1:0] link_ra;
  logic [PW-1:0]  link_rd;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_bytes_r  <= bpa_pkg::BLK_BYTES_RST;
      pool_bytes_r <= bpa_pkg::POOL_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpa_pkg::CFG_BLK_BYTES:  blk_bytes_r  <= cfg_wdata[bpa_pkg::BLK_BYTES_W-1:0];
        bpa_pkg::CFG_POOL_BYTES: pool_bytes_r <= cfg_wdata[bpa_pkg::POOL_BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_kind_r <= in_kind;
      item_id_r   <= in_block_id;
    end
  end

  bpa_cap_check #(
    .PW (PW)
  ) u_cap (
    .appended   (appended),
    .blk_bytes  (blk_bytes_r),
    .pool_bytes (pool_bytes_r),
    .cap_ok     (cap_ok)
  );

  bpa_link_mem #(
    .DEPTH (MAX_BLOCKS),
    .AW    (IDW),
    .DW    (PW)
  ) u_link (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_wa),
    .wr_data (link_wd),
    .rd_addr (link_ra),
    .rd_data (link_rd)
  );

  bpa_core #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .IDW        (IDW),
    .PW         (PW)
  ) u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (item_valid_r),
    .item_kind          (item_kind_r),
    .item_id            (item_id_r),
    .cap_ok             (cap_ok),
    .link_rd            (link_rd),
    .appended           (appended),
    .link_we            (link_we),
    .link_wa            (link_wa),
    .link_wd            (link_wd),
    .link_ra            (link_ra),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_granted_id     (out_granted_id),
    .out_used_count     (out_used_count),
    .out_appended_count (out_appended_count)
  );

endmodule

[design/bpa_checker.sv]
// Port-level checks for the block pool allocator, bound to the top level.
module bpa_checker #(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   start,
  input logic                                   busy,
  input logic                                   out_valid,
  input bpa_pkg::status_t                       out_status,
  input logic [$clog2(MAX_BLOCKS)-1:0]          out_granted_id,
  input logic [$clog2(MAX_BLOCKS+1)-1:0]        out_used_count,
  input logic [$clog2(MAX_BLOCKS+1)-1:0]        out_appended_count
);

  localparam int unsigned IDW = $clog2(MAX_BLOCKS);

  // every item gives exactly one result
  a_item_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("item accepted without a result two cycles later");

  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without a matching item");

  // an appended block is always the newest one
  a_append_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == bpa_pkg::ST_APPENDED))
      |-> (out_granted_id == IDW'(out_appended_count - 1'b1)))
    else $error("appended block id does not match appended count");

  // a rejected request leaves both counts where the previous result left them
  a_reject_keeps_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid) &&
     ((out_status == bpa_pkg::ST_BADID) || (out_status == bpa_pkg::ST_NOMEM)))
      |-> ($stable(out_used_count) && $stable(out_appended_count)
           && (out_granted_id == '0)))
    else $error("rejected request changed the counts or granted a block");

endmodule

bind block_pool_allocator_unit bpa_checker #(.MAX_BLOCKS(MAX_BLOCKS)) u_bpa_checker (.*);

[bench/block_pool_allocator_unit_tb.sv]
// Self-checking testbench for the block pool allocator unit: directed table, then random phases.
module block_pool_allocator_unit_tb;

  localparam int unsigned MAX_BLOCKS = 1024;
  localparam int unsigned ID_W       = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned BB_W       = bpa_pkg::BLK_BYTES_W;
  localparam int unsigned PB_W       = bpa_pkg::POOL_BYTES_W;

  typedef struct packed {
    bpa_pkg::status_t st;
    logic [ID_W-1:0]  gid;
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] app;
  } alloc_res_t;

  typedef enum logic {ROW_REQ, ROW_SIZES} row_op_t;

  typedef struct {
    row_op_t                 op;
    logic                    kind;
    logic [ID_W-1:0]         id;
    bit                      typed;
    alloc_res_t              want;
    logic [BB_W-1:0]         bs;
    logic [PB_W-1:0]         ts;
  } row_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   start       = 1'b0;
  logic                   busy;
  logic                   in_kind     = bpa_pkg::KIND_ALLOC;
  logic [ID_W-1:0]        in_block_id = '0;
  logic                   out_valid;
  bpa_pkg::status_t       out_status;
  logic [ID_W-1:0]        out_granted_id;
  logic [CNT_W-1:0]       out_used_count;
  logic [CNT_W-1:0]       out_appended_count;
  logic                   cfg_we      = 1'b0;
  bpa_pkg::cfg_index_t    cfg_index   = bpa_pkg::CFG_BLK_BYTES;
  logic [bpa_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // hand-typed expectation travelling alongside a directed item
  bit                     item_typed  = 1'b0;
  alloc_res_t             item_want   = '0;

  // pool shadow state
  logic [BB_W-1:0]         pool_blk_bytes;
  logic [PB_W-1:0]         pool_pool_bytes;
  int unsigned             pool_head;
  int unsigned             pool_appended;
  int unsigned             pool_used;
  int unsigned             pool_link [MAX_BLOCKS];
  bit                      pool_taken [MAX_BLOCKS];

  alloc_res_t  due_results [$];
  row_t        directed_q [$];
  int unsigned errors     = 0;
  int          burst_left = 0;

  always #5 clk = ~clk;

  block_pool_allocator_unit #(.MAX_BLOCKS(MAX_BLOCKS)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_block_id        (in_block_id),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_granted_id     (out_granted_id),
    .out_used_count     (out_used_count),
    .out_appended_count (out_appended_count),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // Applies one request to the shadow pool and returns the result it should give.
  function automatic alloc_res_t pool_step(logic kind, logic [ID_W-1:0] id);
    alloc_res_t  r;
    int unsigned b;
    r.gid = '0;
    if (kind == bpa_pkg::KIND_ALLOC) begin
      if (pool_head < MAX_BLOCKS) begin
        b = pool_head;
        pool_head = pool_link[b];
        pool_link[b] = MAX_BLOCKS;
        pool_taken[b] = 1'b1;
        if (pool_used < MAX_BLOCKS) pool_used++;
        r.gid = ID_W'(b);
        r.st = bpa_pkg::ST_REUSED;
      end else if (pool_appended < MAX_BLOCKS &&
                   (64'(pool_appended) + 64'd1) * 64'(pool_blk_bytes) <=
                   64'(pool_pool_bytes)) begin
        b = pool_appended;
        pool_appended++;
        pool_link[b] = MAX_BLOCKS;
        pool_taken[b] = 1'b1;
        if (pool_used < MAX_BLOCKS) pool_used++;
        r.gid = ID_W'(b);
        r.st = bpa_pkg::ST_APPENDED;
      end else begin
        r.st = bpa_pkg::ST_NOMEM;
      end
    end else begin
      if (int'(id) < pool_appended) begin
        pool_taken[id] = 1'b0;
        pool_link[id] = pool_head;
        pool_head = id;
        if (pool_used > 0) pool_used--;
        r.st = bpa_pkg::ST_FREED;
      end else begin
        r.st = bpa_pkg::ST_BADID;
      end
    end
    r.used = CNT_W'(pool_used);
    r.app  = CNT_W'(pool_appended);
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // request side: track config writes and every accepted item
  always @(posedge clk) begin
    alloc_res_t r;
    if (!rst_n) begin
      pool_blk_bytes  = bpa_pkg::BLK_BYTES_RST;
      pool_pool_bytes = bpa_pkg::POOL_BYTES_RST;
      pool_head       = MAX_BLOCKS;
      pool_appended   = 0;
      pool_used       = 0;
      foreach (pool_link[i]) begin
        pool_link[i]  = MAX_BLOCKS;
        pool_taken[i] = 1'b0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == bpa_pkg::CFG_BLK_BYTES) pool_blk_bytes = cfg_wdata[BB_W-1:0];
        else pool_pool_bytes = cfg_wdata[PB_W-1:0];
      end
      if (start && !busy) begin
        r = pool_step(in_kind, in_block_id);
        due_results.push_back(item_typed ? item_want : r);
      end
    end
  end

  // result side
  always @(posedge clk) begin
    alloc_res_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (due_results.size() == 0) begin
        report("unexpected result, status", out_status, 0);
      end else begin
        want = due_results.pop_front();
        if (out_status !== want.st) report("status", out_status, want.st);
        if (out_granted_id !== want.gid) report("granted_id", out_granted_id, want.gid);
        if (out_used_count !== want.used) report("used_count", out_used_count, want.used);
        if (out_appended_count !== want.app)
          report("appended_count", out_appended_count, want.app);
      end
    end
  end

  // Sends one item; bursts of random length with random gaps between them.
  task automatic issue(logic kind, logic [ID_W-1:0] id, bit typed, alloc_res_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start       <= 1'b1;
    in_kind     <= kind;
    in_block_id <= id;
    item_typed  <= typed;
    item_want   <= want;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic settle();
    start <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (due_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_sizes(logic [BB_W-1:0] bs, logic [PB_W-1:0] ts);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= bpa_pkg::CFG_BLK_BYTES;
    cfg_wdata <= bpa_pkg::CFG_DATA_W'(bs);
    @(posedge clk);
    cfg_index <= bpa_pkg::CFG_POOL_BYTES;
    cfg_wdata <= bpa_pkg::CFG_DATA_W'(ts);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // alloc_pct% allocs; else mostly frees of used blocks, some double frees and raw ids as noise.
  task automatic random_item(int alloc_pct);
    logic [ID_W-1:0] id;
    int              pick;
    id = ID_W'($urandom);
    if ($urandom_range(0, 99) < alloc_pct) begin
      issue(bpa_pkg::KIND_ALLOC, id, 1'b0, '0);
    end else begin
      pick = $urandom_range(0, 9);
      if (pool_appended > 0 && pick < 7) begin
        id = ID_W'($urandom_range(0, pool_appended - 1));
        for (int k = 0; k < 8 && !pool_taken[id]; k++)
          id = ID_W'($urandom_range(0, pool_appended - 1));
      end else if (pool_appended > 0 && pick < 8) begin
        id = ID_W'($urandom_range(0, pool_appended - 1));
      end
      issue(bpa_pkg::KIND_FREE, id, 1'b0, '0);
    end
  endtask

  function automatic row_t req(logic kind, int id);
    row_t r;
    r = '{ROW_REQ, kind, ID_W'(id), 1'b0, '0, '0, '0};
    return r;
  endfunction

  function automatic row_t chk(logic kind, int id, bpa_pkg::status_t st, int g, int u, int a);
    row_t r;
    r = '{ROW_REQ, kind, ID_W'(id), 1'b1, '{st, ID_W'(g), CNT_W'(u), CNT_W'(a)}, '0, '0};
    return r;
  endfunction

  function automatic row_t sizes(longint unsigned bs, longint unsigned ts);
    row_t r;
    r = '{ROW_SIZES, bpa_pkg::KIND_ALLOC, '0, 1'b0, '0, BB_W'(bs), PB_W'(ts)};
    return r;
  endfunction

  initial begin
    row_t row;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset sizes: 64-byte blocks in a 64 KiB pool
    directed_q.push_back(chk(bpa_pkg::KIND_FREE,  0,    bpa_pkg::ST_BADID,    0, 0, 0));
    directed_q.push_back(chk(bpa_pkg::KIND_FREE,  1023, bpa_pkg::ST_BADID,    0, 0, 0));
    directed_q.push_back(chk(bpa_pkg::KIND_ALLOC, 1023, bpa_pkg::ST_APPENDED, 0, 1, 1));
    directed_q.push_back(chk(bpa_pkg::KIND_ALLOC, 0,    bpa_pkg::ST_APPENDED, 1, 2, 2));
    directed_q.push_back(chk(bpa_pkg::KIND_ALLOC, 0,    bpa_pkg::ST_APPENDED, 2, 3, 3));
    directed_q.push_back(chk(bpa_pkg::KIND_FREE,  1,    bpa_pkg::ST_FREED,    0, 2, 3));
    // double free
    directed_q.push_back(chk(bpa_pkg::KIND_FREE,  1,    bpa_pkg::ST_FREED,    0, 1, 3));
    directed_q.push_back(chk(bpa_pkg::KIND_ALLOC, 0,    bpa_pkg::ST_REUSED,   1, 2, 3));
    // same block again
    directed_q.push_back(chk(bpa_pkg::KIND_ALLOC, 0,    bpa_pkg::ST_REUSED,   1, 3, 3));
    directed_q.push_back(chk(bpa_pkg::KIND_ALLOC, 0,    bpa_pkg::ST_APPENDED, 3, 4, 4));
    // not yet appended
    directed_q.push_back(chk(bpa_pkg::KIND_FREE,  4,    bpa_pkg::ST_BADID,    0, 4, 4));
    directed_q.push_back(chk(bpa_pkg::KIND_FREE,  3,    bpa_pkg::ST_FREED,    0, 3, 4));
    directed_q.push_back(chk(bpa_pkg::KIND_FREE,  0,    bpa_pkg::ST_FREED,    0, 2, 4));
    // LIFO order
    directed_q.push_back(chk(bpa_pkg::KIND_ALLOC, 0,    bpa_pkg::ST_REUSED,   0, 3, 4));
    directed_q.push_back(chk(bpa_pkg::KIND_ALLOC, 0,    bpa_pkg::ST_REUSED,   3, 4, 4));
    // in-use count runs down to zero and must hold there
    repeat (6) directed_q.push_back(req(bpa_pkg::KIND_FREE, 2));
    // zero block size: only the block bound limits appending
    directed_q.push_back(sizes(0, 0));
    repeat (3) directed_q.push_back(req(bpa_pkg::KIND_ALLOC, 0));
    directed_q.push_back(sizes(1, 0));
    directed_q.push_back(req(bpa_pkg::KIND_ALLOC, 682));
    directed_q.push_back(req(bpa_pkg::KIND_FREE, 1023));

    foreach (directed_q[i]) begin
      row = directed_q[i];
      if (row.op == ROW_SIZES) set_sizes(row.bs, row.ts);
      else issue(row.kind, row.id, row.typed, row.want);
    end

    set_sizes(24'd100, 34'd1000);
    repeat (30) random_item(60);
    set_sizes(24'd1, 34'd0);
    repeat (20) random_item(50);
    set_sizes(24'd3, 34'd50);
    repeat (30) random_item(55);
    // widest sizes: fill the pool right up to the block bound
    set_sizes({BB_W{1'b1}}, {PB_W{1'b1}});
    while (pool_appended < MAX_BLOCKS) random_item(95);
    repeat (40) random_item(50);
    set_sizes(24'd0, 34'd0);
    repeat (20) random_item(60);

    settle();
    if (errors == 0 && due_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[block_pool_allocator_unit.f]
design/bpa_pkg.sv
design/bpa_cap_check.sv
design/bpa_link_mem.sv
design/bpa_core.sv
design/block_pool_allocator_unit.sv
design/bpa_checker.sv
bench/block_pool_allocator_unit_tb.sv
